// ===== src/toc_pkg.sv =====
// Shared types, constants and the arctangent table of the tilt orientation classifier.
package toc_pkg;

  localparam int SAMPLE_BITS_DEF  = 20;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_STEPS        = 24;
  localparam int DATA_W           = 64;
  localparam int ANG_W            = 20;
  localparam int LIMIT_W          = 20;
  localparam int FLAT_W           = 7;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 20;
  localparam int QUEUE_DEPTH      = 2;
  localparam int GAIN_W           = 17;
  localparam logic [GAIN_W-1:0] GAIN_Q16 = 17'd107922;

  localparam logic [LIMIT_W-1:0] MISMATCH_RESET = 20'd100000;
  localparam logic [FLAT_W-1:0]  FLAT_RESET     = 7'd70;

  localparam logic signed [ANG_W-1:0] DEG_10   = 20'sd2560;
  localparam logic signed [ANG_W-1:0] DEG_45   = 20'sd11520;
  localparam logic signed [ANG_W-1:0] DEG_80   = 20'sd20480;
  localparam logic signed [ANG_W-1:0] DEG_100  = 20'sd25600;
  localparam logic signed [ANG_W-1:0] DEG_135  = 20'sd34560;
  localparam logic signed [ANG_W-1:0] DEG_170  = 20'sd43520;
  localparam logic signed [ANG_W-1:0] DEG_180  = 20'sd46080;
  localparam logic signed [ANG_W-1:0] DEG_360  = 20'sd92160;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MISMATCH_LIMIT = 2'd0,
    REG_FLAT_LATITUDE  = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OR_FLAT  = 3'd0,
    OR_UP    = 3'd1,
    OR_DOWN  = 3'd2,
    OR_LEFT  = 3'd3,
    OR_RIGHT = 3'd4
  } orient_t;

  typedef enum logic [1:0] {
    FF_LAPTOP    = 2'd0,
    FF_TABLET    = 2'd1,
    FF_UNDEFINED = 2'd2,
    FF_BORDER    = 2'd3
  } form_t;

  typedef struct packed {
    logic       sample_bad;
    logic [2:0] orientation;
    logic [1:0] form_factor;
    logic       rotate_request;
    logic [1:0] rotation_target;
    logic       keyboard_update;
    logic       keyboard_enable;
  } result_t;

  // round(256 * atan(2^-i)) in degrees
  function automatic logic [13:0] atan_q8(input logic [4:0] i);
    logic [13:0] v;
    case (i)
      5'd0:    v = 14'd11520;
      5'd1:    v = 14'd6801;
      5'd2:    v = 14'd3593;
      5'd3:    v = 14'd1824;
      5'd4:    v = 14'd916;
      5'd5:    v = 14'd458;
      5'd6:    v = 14'd229;
      5'd7:    v = 14'd115;
      5'd8:    v = 14'd57;
      5'd9:    v = 14'd29;
      5'd10:   v = 14'd14;
      5'd11:   v = 14'd7;
      5'd12:   v = 14'd4;
      5'd13:   v = 14'd2;
      5'd14:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/toc_queue.sv =====
// Small first-in first-out queue of words, show-ahead read.
module toc_queue
  import toc_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

// ===== src/toc_front.sv =====
// Front end: pair mismatch check and pair sums of one reading.
module toc_front
  import toc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic signed [SAMPLE_BITS-1:0]   first_axis  [6],
  input  logic signed [SAMPLE_BITS-1:0]   second_axis [6],
  input  logic        [LIMIT_W-1:0]       mismatch_limit,
  output logic                            bad,
  output logic signed [SAMPLE_BITS:0]     sums [6]
);
  localparam int SW = SAMPLE_BITS + 1;
  localparam int KW = (SW > LIMIT_W) ? SW : LIMIT_W;

  always_comb begin
    logic signed [SW-1:0] a, b, d;
    logic [KW-1:0]        dabs;
    bad = 1'b0;
    for (int j = 0; j < 6; j++) begin
      a = SW'(first_axis[j]);
      b = SW'(second_axis[j]);
      d = a - b;
      dabs = KW'(unsigned'(d[SW-1] ? -d : d));
      if (dabs > KW'(mismatch_limit)) begin
        bad = 1'b1;
      end
      sums[j] = a + b;
    end
  end
endmodule

// ===== src/toc_cordic.sv =====
// Iterative vectoring CORDIC: Q8 degree angle and gain-scaled magnitude.
module toc_cordic
  import toc_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] x_in,
  input  logic signed [DATA_W-1:0] y_in,
  output logic                     done,
  output logic signed [ANG_W-1:0]  angle,
  output logic signed [DATA_W-1:0] mag
);
  localparam int N = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

  logic                     busy;
  logic [4:0]               step;
  logic signed [DATA_W-1:0] x, y;
  logic signed [ANG_W-1:0]  a;
  logic signed [DATA_W-1:0] dx, dy;
  logic signed [ANG_W-1:0]  da;

  assign dx    = y >>> step;
  assign dy    = x >>> step;
  assign da    = ANG_W'(atan_q8(step));
  assign angle = a;
  assign mag   = x;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        step <= '0;
        if (x_in == '0 && y_in == '0) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == 5'(N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      if (x_in == '0 && y_in == '0) begin
        x <= '0;
        y <= '0;
        a <= '0;
      end else if (x_in[DATA_W-1]) begin
        // left half plane: mirror and start from half a turn
        x <= -x_in;
        y <= -y_in;
        a <= y_in[DATA_W-1] ? -DEG_180 : DEG_180;
      end else begin
        x <= x_in;
        y <= y_in;
        a <= '0;
      end
    end else if (busy) begin
      if (!y[DATA_W-1]) begin
        x <= x + dx;
        y <= y - dy;
        a <= a + da;
      end else begin
        x <= x - dx;
        y <= y + dy;
        a <= a - da;
      end
    end
  end
endmodule

// ===== src/toc_back.sv =====
// Back end: angle sequencer, classification, class state and result queue.
module toc_back
  import toc_pkg::*;
#(
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          mid_empty,
  input  logic                          mid_bad,
  input  logic signed [SAMPLE_BITS:0]   mid_sums [6],
  output logic                          mid_pop,
  input  logic [FLAT_W-1:0]             flat_latitude_deg,
  input  logic                          pop,
  output logic                          empty,
  output result_t                       result
);
  localparam int SW    = SAMPLE_BITS + 1;
  localparam int GUARD = 59 - SAMPLE_BITS;
  localparam int PW    = SW + GAIN_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LON   = 7'b0000010,
    S_LAT   = 7'b0000100,
    S_TS    = 7'b0001000,
    S_TK    = 7'b0010000,
    S_TILT  = 7'b0100000,
    S_CLASS = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic signed [DATA_W-1:0] sx, sz, kx, kz, zk;
  logic signed [ANG_W-1:0]  lon, lat, ts, tilt;
  logic [2:0]               last_orientation;
  logic [1:0]               last_form_factor;

  logic                     c_start, c_done;
  logic signed [DATA_W-1:0] c_x, c_y, c_mag;
  logic signed [ANG_W-1:0]  c_angle;

  logic                     out_push, out_full;
  result_t                  out_word;

  logic signed [DATA_W-1:0] in_sx, in_sy, in_sz, in_kx, in_kz, in_zk;
  logic [SW-1:0]            zabs;
  logic [PW-1:0]            zprod;
  logic [DATA_W-1:0]        zmag;

  function automatic logic signed [DATA_W-1:0] scale(input logic signed [SW-1:0] s);
    return DATA_W'(s) <<< GUARD;
  endfunction

  // screen axes, keyboard turned about z: x' = y
  assign in_sx = scale(mid_sums[0]);
  assign in_sy = scale(mid_sums[1]);
  assign in_sz = scale(mid_sums[2]);
  assign in_kx = scale(mid_sums[4]);
  assign in_kz = scale(mid_sums[5]);
  assign zabs  = mid_sums[2][SW-1] ? unsigned'(-mid_sums[2]) : unsigned'(mid_sums[2]);
  assign zprod = PW'(zabs) * PW'(GAIN_Q16);
  assign zmag  = DATA_W'(zprod) << (GUARD - 16);
  assign in_zk = mid_sums[2][SW-1] ? -signed'(zmag) : signed'(zmag);

  toc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (c_start),
    .x_in  (c_x),
    .y_in  (c_y),
    .done  (c_done),
    .angle (c_angle),
    .mag   (c_mag)
  );

  // classification of the finished angles
  logic signed [ANG_W-1:0] alon, lat_lim, tilt_raw, tilt_wrap;
  logic [2:0]              orient;
  logic [1:0]              ff;
  logic                    rot_req, kb_upd;

  assign tilt_raw = ts - c_angle;
  always_comb begin
    tilt_wrap = tilt_raw;
    if (tilt_raw > DEG_180) begin
      tilt_wrap = tilt_raw - DEG_360;
    end else if (tilt_raw < -DEG_180) begin
      tilt_wrap = tilt_raw + DEG_360;
    end
  end

  assign alon    = lon[ANG_W-1] ? -lon : lon;
  assign lat_lim = ANG_W'(flat_latitude_deg) <<< 8;

  always_comb begin
    if (lat > lat_lim || lat < -lat_lim) begin
      orient = OR_FLAT;
    end else if (alon > DEG_135) begin
      orient = OR_UP;
    end else if (alon < DEG_45) begin
      orient = OR_DOWN;
    end else if (lon[ANG_W-1]) begin
      orient = OR_RIGHT;
    end else begin
      orient = OR_LEFT;
    end
    if (alon > DEG_80 && alon < DEG_100) begin
      ff = FF_UNDEFINED;
    end else if (tilt > -DEG_170 && tilt < -DEG_10) begin
      ff = FF_LAPTOP;
    end else if (tilt > DEG_10 || tilt <= -DEG_170) begin
      ff = FF_TABLET;
    end else begin
      ff = FF_BORDER;
    end
  end

  assign rot_req = (orient != OR_FLAT) && (orient != last_orientation);
  assign kb_upd  = (ff == FF_LAPTOP || ff == FF_TABLET) && (ff != last_form_factor);

  always_comb begin
    state_next = state;
    mid_pop    = 1'b0;
    out_push   = 1'b0;
    out_word   = '0;
    c_start    = 1'b0;
    c_x        = sx;
    c_y        = sz;
    case (state)
      S_IDLE: begin
        if (!mid_empty && !out_full) begin
          mid_pop = 1'b1;
          if (mid_bad) begin
            out_push            = 1'b1;
            out_word.sample_bad = 1'b1;
          end else begin
            c_start    = 1'b1;
            c_x        = in_sx;
            c_y        = in_sy;
            state_next = S_LON;
          end
        end
      end
      S_LON: begin
        if (c_done) begin
          c_start    = 1'b1;
          c_x        = c_mag;
          c_y        = zk;
          state_next = S_LAT;
        end
      end
      S_LAT: begin
        if (c_done) begin
          c_start    = 1'b1;
          state_next = S_TS;
        end
      end
      S_TS: begin
        if (c_done) begin
          c_start    = 1'b1;
          c_x        = kx;
          c_y        = kz;
          state_next = S_TK;
        end
      end
      S_TK: begin
        if (c_done) begin
          state_next = S_TILT;
        end
      end
      S_TILT: begin
        state_next = S_CLASS;
      end
      S_CLASS: begin
        out_push                 = 1'b1;
        out_word.orientation     = orient;
        out_word.form_factor     = ff;
        out_word.rotate_request  = rot_req;
        out_word.rotation_target = rot_req ? 2'(orient - 3'd1) : 2'd0;
        out_word.keyboard_update = kb_upd;
        out_word.keyboard_enable = kb_upd && (ff == FF_LAPTOP);
        state_next               = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      last_orientation <= OR_FLAT;
      last_form_factor <= FF_UNDEFINED;
    end else begin
      state <= state_next;
      if (state == S_CLASS) begin
        if (rot_req) begin
          last_orientation <= orient;
        end
        if (kb_upd) begin
          last_form_factor <= ff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      sx <= in_sx;
      sz <= in_sz;
      kx <= in_kx;
      kz <= in_kz;
      zk <= in_zk;
    end
    if (state == S_LON && c_done) begin
      lon <= c_angle;
    end
    if (state == S_LAT && c_done) begin
      lat <= c_angle;
    end
    if (state == S_TS && c_done) begin
      ts <= c_angle;
    end
    if (state == S_TK && c_done) begin
      tilt <= tilt_wrap;
    end
  end

  toc_queue #(.W($bits(result_t)), .DEPTH(QUEUE_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_word),
    .full  (out_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );
endmodule

// ===== src/tilt_orientation_classifier.sv =====
// Top level of the tilt orientation classifier.
//
// Input channel: one word is a reading of four accelerometers (screen and
// keyboard pair, three axes each); it is taken on a clock edge with push
// high and full low. The front end checks the pairs and forms pair sums in
// the same cycle and parks the word in a two-entry queue.
// Result channel: the oldest result sits on the result ports while empty is
// low and is taken on an edge with pop high. A stalled receiver only fills
// the two-entry result queue; after that the back end waits, the middle
// queue fills and full goes high.
// Flow: a bad sample enters the result queue on the same edge that takes
// it out of the middle queue. A good sample runs four CORDIC passes on one
// shared iterative unit (a zero vector skips the iterations), then tilt wrap,
// classification and the return to idle; only then does the back end take
// the next sample from the middle queue.
// Config channel: cfg_ready is always high; writes take effect at once;
// they must be made only while the block is idle; the block does not check.
// Index 0 mismatch_limit, index 1 flat_latitude_deg, others ignored.
// Reset (rst, synchronous): queues empty, registers to 100000 and 70,
// last orientation flat, last form factor undefined.
module tilt_orientation_classifier
  import toc_pkg::*;
#(
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] screen_first_x,
  input  logic signed [SAMPLE_BITS-1:0] screen_first_y,
  input  logic signed [SAMPLE_BITS-1:0] screen_first_z,
  input  logic signed [SAMPLE_BITS-1:0] keyboard_first_x,
  input  logic signed [SAMPLE_BITS-1:0] keyboard_first_y,
  input  logic signed [SAMPLE_BITS-1:0] keyboard_first_z,
  input  logic signed [SAMPLE_BITS-1:0] screen_second_x,
  input  logic signed [SAMPLE_BITS-1:0] screen_second_y,
  input  logic signed [SAMPLE_BITS-1:0] screen_second_z,
  input  logic signed [SAMPLE_BITS-1:0] keyboard_second_x,
  input  logic signed [SAMPLE_BITS-1:0] keyboard_second_y,
  input  logic signed [SAMPLE_BITS-1:0] keyboard_second_z,
  output logic                          empty,
  input  logic                          pop,
  output logic                          sample_bad,
  output logic [2:0]                    orientation,
  output logic [1:0]                    form_factor,
  output logic                          rotate_request,
  output logic [1:0]                    rotation_target,
  output logic                          keyboard_update,
  output logic                          keyboard_enable,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);
  localparam int SW = SAMPLE_BITS + 1;
  localparam int MW = 1 + 6 * SW;

  logic [LIMIT_W-1:0] mismatch_limit;
  logic [FLAT_W-1:0]  flat_latitude_deg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mismatch_limit    <= MISMATCH_RESET;
      flat_latitude_deg <= FLAT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MISMATCH_LIMIT: mismatch_limit    <= cfg_data[LIMIT_W-1:0];
        REG_FLAT_LATITUDE:  flat_latitude_deg <= cfg_data[FLAT_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [SAMPLE_BITS-1:0] first_axis  [6];
  logic signed [SAMPLE_BITS-1:0] second_axis [6];
  logic signed [SW-1:0]          f_sums [6];
  logic signed [SW-1:0]          m_sums [6];
  logic                          f_bad;
  logic [MW-1:0]                 mid_in, mid_out;
  logic                          mid_empty, mid_pop;
  result_t                       result;

  assign first_axis  = '{screen_first_x, screen_first_y, screen_first_z,
                         keyboard_first_x, keyboard_first_y, keyboard_first_z};
  assign second_axis = '{screen_second_x, screen_second_y, screen_second_z,
                         keyboard_second_x, keyboard_second_y, keyboard_second_z};

  toc_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .first_axis     (first_axis),
    .second_axis    (second_axis),
    .mismatch_limit (mismatch_limit),
    .bad            (f_bad),
    .sums           (f_sums)
  );

  // middle queue word: bad flag over the six pair sums
  always_comb begin
    mid_in[MW-1] = f_bad;
    for (int j = 0; j < 6; j++) begin
      mid_in[j*SW +: SW] = f_sums[j];
      m_sums[j]          = mid_out[j*SW +: SW];
    end
  end

  toc_queue #(.W(MW), .DEPTH(QUEUE_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (mid_in),
    .full  (full),
    .pop   (mid_pop),
    .rdata (mid_out),
    .empty (mid_empty)
  );

  toc_back #(.SAMPLE_BITS(SAMPLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk               (clk),
    .rst               (rst),
    .mid_empty         (mid_empty),
    .mid_bad           (mid_out[MW-1]),
    .mid_sums          (m_sums),
    .mid_pop           (mid_pop),
    .flat_latitude_deg (flat_latitude_deg),
    .pop               (pop),
    .empty             (empty),
    .result            (result)
  );

  assign sample_bad      = result.sample_bad;
  assign orientation     = result.orientation;
  assign form_factor     = result.form_factor;
  assign rotate_request  = result.rotate_request;
  assign rotation_target = result.rotation_target;
  assign keyboard_update = result.keyboard_update;
  assign keyboard_enable = result.keyboard_enable;
endmodule

// ===== src/toc_checker.sv =====
// Port-level checker of the tilt orientation classifier, with its bind.
module toc_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       sample_bad,
  input logic [2:0] orientation,
  input logic [1:0] form_factor,
  input logic       rotate_request,
  input logic [1:0] rotation_target,
  input logic       keyboard_update,
  input logic       keyboard_enable
);
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && sample_bad) |-> (orientation == 3'd0 && form_factor == 2'd0 &&
      !rotate_request && !keyboard_update))
    else $error("bad sample carries class fields");

  a_flat_no_turn: assert property (@(posedge clk) disable iff (rst)
    (!empty && orientation == 3'd0) |-> (!rotate_request && rotation_target == 2'd0))
    else $error("rotation requested while flat");

  a_kb_quiet: assert property (@(posedge clk) disable iff (rst)
    (!empty && !keyboard_update) |-> !keyboard_enable)
    else $error("keyboard enable without update");
endmodule

bind tilt_orientation_classifier toc_checker u_toc_checker (
  .clk             (clk),
  .rst             (rst),
  .empty           (empty),
  .sample_bad      (sample_bad),
  .orientation     (orientation),
  .form_factor     (form_factor),
  .rotate_request  (rotate_request),
  .rotation_target (rotation_target),
  .keyboard_update (keyboard_update),
  .keyboard_enable (keyboard_enable)
);
